>>> hw/rtl/lru_key_value_cache_defines.svh
// Assertion macros shared by the cache checker.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Check a same-cycle implication at every clock edge outside reset.
`define LRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication whose consequent lands in the cycle after the antecedent.
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lru_kv_pkg.sv
// Shared constants and controller/datapath interface types for the LRU cache.
`default_nettype none

package lru_kv_pkg;

    localparam int LRU_MAX_ENTRIES = 16;
    localparam int DATA_W          = 32;
    localparam int CFG_W           = 5;

    localparam logic [CFG_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    // Operation code carried by func
    localparam logic FUNC_PUT = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;       // capture request, start key scan
        logic put_update;  // overwrite hit value, start touch sweep
        logic insert;      // evict if full, write new entry, start aging sweep
        logic touch;       // start touch sweep for a get hit
        logic emit;        // load the result register
    } lru_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_put;
        logic hit;
        logic pass_done;
        logic out_free;
    } lru_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/lru_kv_ctrl.sv
// Request sequencer of the LRU cache: scan, decide, report, rank sweep.
`default_nettype none

module lru_kv_ctrl
    import lru_kv_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  lru_status_t status,
    output lru_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RESULT,
        ST_SWEEP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Advance through the request phases and issue datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.pass_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!status.is_put)
                begin
                    state_next = ST_RESULT;
                end
                else if (status.hit)
                begin
                    cmd.put_update = 1'b1;
                    state_next     = ST_SWEEP;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    state_next = ST_SWEEP;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.hit)
                    begin
                        cmd.touch  = 1'b1;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (status.pass_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/lru_kv_dpath.sv
// Entry storage, sequential key scan, rank sweep and result register of the LRU cache.
`default_nettype none

module lru_kv_dpath
    import lru_kv_pkg::*;
#(
    parameter int MAX_ENTRIES = LRU_MAX_ENTRIES
)
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  lru_cmd_t                  cmd,
    output lru_status_t               status,
    input  wire                       func,
    input  wire signed [DATA_W-1:0]   lookup_key,
    input  wire signed [DATA_W-1:0]   write_value,
    input  wire                       cfg_write_en,
    input  wire        [CFG_W-1:0]    cfg_write_data,
    output logic                      out_valid,
    input  wire                       out_ready,
    output logic signed [DATA_W-1:0]  read_value,
    output logic                      found
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
    localparam logic [CAP_W-1:0] MAX_CAP  = CAP_W'(MAX_ENTRIES);

    // Entry memories
    logic [DATA_W-1:0] key_mem   [MAX_ENTRIES];
    logic [DATA_W-1:0] value_mem [MAX_ENTRIES];
    logic [IDX_W-1:0]  rank_mem  [MAX_ENTRIES];

    logic [DATA_W-1:0] key_rd_reg;
    logic [DATA_W-1:0] value_rd_reg;
    logic [IDX_W-1:0]  rank_rd_reg;

    // Request capture
    logic              func_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] wval_reg;

    // Pass sequencing
    logic              pass_run_reg;
    logic              sweep_reg;
    logic [IDX_W-1:0]  ctr_reg;
    logic              st_vld_reg;
    logic [IDX_W-1:0]  st_idx_reg;

    // Scan findings
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [IDX_W-1:0]  hit_rank_reg;
    logic [DATA_W-1:0] hit_value_reg;
    logic              vic_found_reg;
    logic [IDX_W-1:0]  vic_idx_reg;
    logic [IDX_W-1:0]  vic_rank_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    // Sweep control
    logic [IDX_W-1:0]  target_reg;
    logic [IDX_W-1:0]  thr_reg;
    logic              all_reg;

    // Occupancy, capacity, valid marks
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0]       occ_reg;
    logic [CFG_W-1:0]       cap_reg;

    // Result register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_found_reg;

    logic [CAP_W-1:0]  cap_ext;
    logic [CAP_W-1:0]  eff_cap;
    logic              full;
    logic [IDX_W-1:0]  slot_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  rank_next;
    logic              pass_start;
    logic              rank_we;

    // Clamp capacity to 1..MAX_ENTRIES and test for a full cache
    always_comb
    begin
        cap_ext = CAP_W'(cap_reg);
        if (cap_reg == '0)
        begin
            eff_cap = CAP_W'(1);
        end
        else if (cap_ext > MAX_CAP)
        begin
            eff_cap = MAX_CAP;
        end
        else
        begin
            eff_cap = cap_ext;
        end
        full = (CAP_W'(occ_reg) >= eff_cap) && (occ_reg != '0);
    end

    // Pick the insert slot: lowest invalid entry once the victim is dropped
    always_comb
    begin
        if (full && !(free_found_reg && (free_idx_reg < vic_idx_reg)))
        begin
            slot_idx = vic_idx_reg;
        end
        else
        begin
            slot_idx = free_idx_reg;
        end
        wr_idx = cmd.insert ? slot_idx : hit_idx_reg;
    end

    // Drop the victim when full and mark the insert slot
    always_comb
    begin
        valid_next = valid_reg;
        if (full)
        begin
            valid_next[vic_idx_reg] = 1'b0;
        end
        valid_next[slot_idx] = 1'b1;
    end

    // New rank of the entry leaving the read stage during a sweep
    always_comb
    begin
        if (st_idx_reg == target_reg)
        begin
            rank_next = '0;
        end
        else if (valid_reg[st_idx_reg] && (all_reg || (rank_rd_reg < thr_reg)))
        begin
            rank_next = rank_rd_reg + IDX_W'(1);
        end
        else
        begin
            rank_next = rank_rd_reg;
        end
    end

    assign pass_start = cmd.start || cmd.put_update || cmd.insert || cmd.touch;
    assign rank_we    = st_vld_reg && sweep_reg;

    // Write and read the entry memories
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            key_mem[wr_idx] <= key_reg;
        end
        if (cmd.insert || cmd.put_update)
        begin
            value_mem[wr_idx] <= wval_reg;
        end
        if (rank_we)
        begin
            rank_mem[st_idx_reg] <= rank_next;
        end
        key_rd_reg   <= key_mem[ctr_reg];
        value_rd_reg <= value_mem[ctr_reg];
        rank_rd_reg  <= rank_mem[ctr_reg];
    end

    // Capture request fields and sweep targets
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg <= func;
            key_reg  <= $unsigned(lookup_key);
            wval_reg <= $unsigned(write_value);
        end
        if (cmd.put_update || cmd.touch)
        begin
            target_reg <= hit_idx_reg;
            thr_reg    <= hit_rank_reg;
            all_reg    <= 1'b0;
        end
        else if (cmd.insert)
        begin
            target_reg <= slot_idx;
            thr_reg    <= '0;
            all_reg    <= 1'b1;
        end
        if (cmd.emit)
        begin
            out_value_reg <= hit_reg ? hit_value_reg : MISS_VALUE;
            out_found_reg <= hit_reg;
        end
    end

    // Sequence passes and gather scan findings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_run_reg   <= 1'b0;
            sweep_reg      <= 1'b0;
            ctr_reg        <= '0;
            st_vld_reg     <= 1'b0;
            st_idx_reg     <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            hit_rank_reg   <= '0;
            hit_value_reg  <= '0;
            vic_found_reg  <= 1'b0;
            vic_idx_reg    <= '0;
            vic_rank_reg   <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            // Step the read address through all entries
            if (pass_start)
            begin
                pass_run_reg <= 1'b1;
                sweep_reg    <= !cmd.start;
                ctr_reg      <= '0;
            end
            else if (pass_run_reg)
            begin
                if (ctr_reg == LAST_IDX)
                begin
                    pass_run_reg <= 1'b0;
                end
                else
                begin
                    ctr_reg <= ctr_reg + IDX_W'(1);
                end
            end
            st_vld_reg <= pass_run_reg && !pass_start;
            st_idx_reg <= ctr_reg;

            // Compare key, track oldest valid entry and first free entry
            if (cmd.start)
            begin
                hit_reg        <= 1'b0;
                vic_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (st_vld_reg && !sweep_reg)
            begin
                if (valid_reg[st_idx_reg])
                begin
                    if (!hit_reg && (key_rd_reg == key_reg))
                    begin
                        hit_reg       <= 1'b1;
                        hit_idx_reg   <= st_idx_reg;
                        hit_rank_reg  <= rank_rd_reg;
                        hit_value_reg <= value_rd_reg;
                    end
                    if (!vic_found_reg || (rank_rd_reg > vic_rank_reg))
                    begin
                        vic_found_reg <= 1'b1;
                        vic_idx_reg   <= st_idx_reg;
                        vic_rank_reg  <= rank_rd_reg;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= st_idx_reg;
                end
            end
        end
    end

    // Hold valid marks, occupancy, capacity and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            occ_reg       <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
            if (cmd.insert)
            begin
                if (!full)
                begin
                    occ_reg <= occ_reg + CNT_W'(1);
                end
                valid_reg <= valid_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.is_put    = (func_reg == FUNC_PUT);
    assign status.hit       = hit_reg;
    assign status.pass_done = st_vld_reg && (st_idx_reg == LAST_IDX);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign read_value = $signed(out_value_reg);
    assign found      = out_found_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lru_key_value_cache.sv
// A get result is loaded into the output register after its key scan over all entries.
// Requests are handled one at a time: a get miss ends after its scan, while a put or a get hit
// also runs a one-entry-per-cycle rank sweep over the entry memories before the next is taken.
// A new request is taken while an earlier result still waits in the output register.
// Reset (rst_n low, asynchronous) clears all valid marks and the occupancy and sets
// the capacity register to 16; no clearing pass follows, the block is ready at once.
`default_nettype none

module lru_key_value_cache
    import lru_kv_pkg::*;
#(
    parameter int MAX_ENTRIES = LRU_MAX_ENTRIES
)
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire                       func,
    input  wire signed [DATA_W-1:0]   lookup_key,
    input  wire signed [DATA_W-1:0]   write_value,
    input  wire                       cfg_write_en,
    input  wire        [CFG_W-1:0]    cfg_write_data,
    output logic                      out_valid,
    input  wire                       out_ready,
    output logic signed [DATA_W-1:0]  read_value,
    output logic                      found
);

    lru_cmd_t    cmd;
    lru_status_t status;

    // Sequence each request
    lru_kv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Store entries and produce results
    lru_kv_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .func           (func),
        .lookup_key     (lookup_key),
        .write_value    (write_value),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_value     (read_value),
        .found          (found)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lru_kv_checker.sv
// Port-level checks of the LRU cache, bound to the top level.
`default_nettype none
`include "lru_key_value_cache_defines.svh"

module lru_kv_checker
    import lru_kv_pkg::*;
(
    input wire                      clk,
    input wire                      rst_n,
    input wire                      in_valid,
    input wire                      in_ready,
    input wire                      out_valid,
    input wire                      out_ready,
    input wire signed [DATA_W-1:0]  read_value,
    input wire                      found
);

    logic              out_stall;
    logic [DATA_W:0]   out_word;

    assign out_stall = out_valid && !out_ready;
    assign out_word  = {read_value, found};

    // A stalled result holds its payload
    `LRU_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "result changed")

    // A miss always reports the all-ones value
    `LRU_ASSERT_NOW(a_miss_value, out_valid && !found, read_value == MISS_VALUE, "miss not -1")

    // An accepted request blocks the next one while it is scanned
    `LRU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "taken during scan")

endmodule

bind lru_key_value_cache lru_kv_checker u_checker (.*);

`default_nettype wire

>>> tb/lru_key_value_cache_tb.sv
// Testbench for the LRU key/value cache: directed and random requests checked against a shadow cache.
`default_nettype none

module lru_key_value_cache_tb;
    import lru_kv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_ENTRIES = LRU_MAX_ENTRIES;
    localparam logic FUNC_GET   = ~FUNC_PUT;
    // A put leaves no result behind, so the settle wait covers its key scan and rank sweep
    localparam int  SETTLE_CYCLES = 3 * MAX_ENTRIES + 8;
    localparam int  LONG_STALL    = 300;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              found;
    } lookup_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    wire                      in_ready;
    logic                     func = FUNC_GET;
    logic signed [DATA_W-1:0] lookup_key = '0;
    logic signed [DATA_W-1:0] write_value = '0;
    logic                     cfg_write_en = 1'b0;
    logic        [CFG_W-1:0]  cfg_write_data = '0;
    wire                      out_valid;
    logic                     out_ready = 1'b0;
    wire signed  [DATA_W-1:0] read_value;
    wire                      found;

    // Shadow copy of the cache contents and the capacity register
    logic [DATA_W-1:0] shadow_key   [MAX_ENTRIES];
    logic [DATA_W-1:0] shadow_value [MAX_ENTRIES];
    logic              shadow_valid [MAX_ENTRIES];
    logic [3:0]        shadow_rank  [MAX_ENTRIES];
    logic [CFG_W-1:0]  shadow_count;
    logic [CFG_W-1:0]  capacity_shadow;

    lookup_result_t pending_lookups [$];
    int             error_count = 0;
    bit             sender_idle_on = 1'b1;
    bit             receiver_idle_on = 1'b1;
    int             long_stall_cycles = 0;

    lru_key_value_cache uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .lookup_key     (lookup_key),
        .write_value    (write_value),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_value     (read_value),
        .found          (found)
    );

    always #1 clk = ~clk;

    // Make one entry the most recent; newer valid entries age by one
    function automatic void promote_entry(int slot);
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (shadow_valid[i] && shadow_rank[i] < shadow_rank[slot])
                shadow_rank[i]++;
        end
        shadow_rank[slot] = '0;
    endfunction

    // Apply one accepted request to the shadow cache and queue the expected lookup result
    function automatic void apply_access(logic op, logic [DATA_W-1:0] key,
                                         logic [DATA_W-1:0] value);
        int             hit;
        int             victim;
        int             slot;
        int             eff_cap;
        lookup_result_t res;
        hit = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == key)
                hit = i;
        end
        if (op == FUNC_GET)
        begin
            if (hit >= 0)
            begin
                promote_entry(hit);
                res.read_value = shadow_value[hit];
                res.found      = 1'b1;
            end
            else
            begin
                res.read_value = MISS_VALUE;
                res.found      = 1'b0;
            end
            pending_lookups.push_back(res);
            return;
        end
        if (hit >= 0)
        begin
            shadow_value[hit] = value;
            promote_entry(hit);
            return;
        end
        // Clamp the capacity to 1..MAX_ENTRIES
        eff_cap = capacity_shadow;
        if (eff_cap < 1)
            eff_cap = 1;
        if (eff_cap > MAX_ENTRIES)
            eff_cap = MAX_ENTRIES;
        // Evict the oldest entry when at or above capacity
        if (shadow_count >= eff_cap && shadow_count > 0)
        begin
            victim = -1;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                    victim = i;
            end
            if (victim >= 0)
            begin
                shadow_valid[victim] = 1'b0;
                shadow_rank[victim]  = '0;
                shadow_count--;
            end
        end
        // Insert into the lowest free slot as most recent
        slot = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (slot < 0 && !shadow_valid[i])
                slot = i;
        end
        if (slot < 0)
            return;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (shadow_valid[i])
                shadow_rank[i]++;
        end
        shadow_key[slot]   = key;
        shadow_value[slot] = value;
        shadow_valid[slot] = 1'b1;
        shadow_rank[slot]  = '0;
        shadow_count++;
    endfunction

    // Track config writes, check each result, then predict each accepted request
    always @(posedge clk)
    begin : monitor
        lookup_result_t want;
        if (rst_n)
        begin
            if (cfg_write_en)
                capacity_shadow = cfg_write_data;
            if (out_valid && out_ready)
            begin
                if (pending_lookups.size() == 0)
                begin
                    $error("unexpected result: read_value %h found %b", read_value, found);
                    error_count++;
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    if (read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, actual %h", want.read_value, read_value);
                        error_count++;
                    end
                    if (found !== want.found)
                    begin
                        $error("found: expected %b, actual %b", want.found, found);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                apply_access(func, lookup_key, write_value);
        end
    end

    // Drive out_ready: long hold-off on request, random bursts, otherwise ready
    initial
    begin : receiver
        int burst;
        forever
        begin
            @(posedge clk);
            if (long_stall_cycles > 0)
            begin
                burst = long_stall_cycles;
                long_stall_cycles = 0;
                out_ready <= 1'b0;
                repeat (burst) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (receiver_idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 12);
                out_ready <= 1'b0;
                repeat (burst) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one request, with an optional idle burst first, and hold it until accepted
    task automatic send_request(input logic op, input logic [DATA_W-1:0] key,
                                input logic [DATA_W-1:0] value);
        int gap;
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        lookup_key  <= key;
        write_value <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending, wait for every expected result, then let any put finish
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (pending_lookups.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the capacity register while the block is idle
    task automatic set_capacity(input logic [CFG_W-1:0] cap);
        wait_for_idle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= cap;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // Field extremes, miss on empty, hit, update, and a stored value equal to the miss value
    task automatic test_field_extremes();
        send_request(FUNC_GET, 32'h0000_0000, $urandom());
        send_request(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_GET, 32'h8000_0000, $urandom());
        send_request(FUNC_GET, 32'h7FFF_FFFF, $urandom());
        send_request(FUNC_GET, 32'h0000_0000, $urandom());
        send_request(FUNC_GET, 32'hFFFF_FFFF, $urandom());
        send_request(FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
        send_request(FUNC_GET, 32'h0000_0000, $urandom());
    endtask

    // Capacity below occupancy, capacity of zero, and capacity above the entry count
    task automatic test_capacity_edges();
        set_capacity(5'd0);
        send_request(FUNC_PUT, 32'hA5A5_0001, 32'h0000_0001);
        send_request(FUNC_GET, 32'h8000_0000, $urandom());
        send_request(FUNC_GET, 32'hA5A5_0001, $urandom());
        send_request(FUNC_PUT, 32'hA5A5_0002, 32'h0000_0002);
        send_request(FUNC_GET, 32'h7FFF_FFFF, $urandom());
        set_capacity(5'd31);
        send_request(FUNC_PUT, 32'h5A5A_0003, 32'hDEAD_BEEF);
        send_request(FUNC_PUT, 32'h5A5A_0004, 32'hCAFE_F00D);
        send_request(FUNC_GET, 32'h5A5A_0003, $urandom());
        set_capacity(5'd1);
        send_request(FUNC_PUT, 32'h0F0F_0005, 32'h0000_0005);
        send_request(FUNC_GET, 32'h0F0F_0005, $urandom());
    endtask

    // Random gets and puts over a key pool sized around the capacity
    task automatic run_random_phase(input logic [CFG_W-1:0] cap, input int count);
        logic [DATA_W-1:0] key_pool [$];
        logic [DATA_W-1:0] key;
        int                eff_cap;
        int                pool_size;
        set_capacity(cap);
        eff_cap = (cap < 1) ? 1 : ((cap > MAX_ENTRIES) ? MAX_ENTRIES : cap);
        pool_size = eff_cap + $urandom_range(1, 6);
        for (int i = 0; i < pool_size; i++)
        begin
            case ($urandom_range(0, 15))
                0:       key_pool.push_back(32'h8000_0000);
                1:       key_pool.push_back(32'h7FFF_FFFF);
                default: key_pool.push_back($urandom());
            endcase
        end
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                key = $urandom();
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            send_request($urandom_range(0, 1) ? FUNC_PUT : FUNC_GET, key, $urandom());
        end
    endtask

    // Hold off the receiver while gets pile up and stall the input
    task automatic test_output_backpressure();
        wait_for_idle();
        sender_idle_on = 1'b0;
        for (int i = 0; i < 8; i++)
            send_request(FUNC_PUT, 32'hC0DE_0000 + i, $urandom());
        long_stall_cycles = LONG_STALL;
        for (int i = 0; i < 32; i++)
            send_request(FUNC_GET, 32'hC0DE_0000 + $urandom_range(0, 11), $urandom());
        wait_for_idle();
        sender_idle_on = 1'b1;
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_full_rate_tail();
        wait_for_idle();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        run_random_phase(5'd16, 200);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_capacity_edges();
        run_random_phase(5'd16, 140);
        run_random_phase(5'd1, 140);
        run_random_phase(5'd0, 140);
        run_random_phase(5'd31, 140);
        run_random_phase(5'd3, 140);
        run_random_phase(5'd2, 140);
        run_random_phase(5'd17, 140);
        run_random_phase(5'd8, 140);
        run_random_phase(5'd12, 140);
        run_random_phase(5'(CAP_RESET), 140);
        test_output_backpressure();
        test_full_rate_tail();
        wait_for_idle();
        if (pending_lookups.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_lookups.size());
            error_count++;
        end
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Bound the run well beyond the slowest legal schedule
    initial
    begin
        #1000000;
        $display("status: fail");
        $finish;
    end

    // Shadow state after reset
    initial
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = '0;
        end
        shadow_count    = '0;
        capacity_shadow = CAP_RESET;
    end

endmodule

`default_nettype wire
